// File: sv/olie_pkg.sv
// ----------------------------------------------------------------------------
// olie_pkg
// Shared types and codes for the ordered list insert/erase block.
// ----------------------------------------------------------------------------
package olie_pkg;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_FRONT  = 3'd6,
    OP_BACK   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CC_HOLD   = 3'd0,
    CC_PUSH   = 3'd1,
    CC_POP    = 3'd2,
    CC_INSERT = 3'd3,
    CC_ERASE  = 3'd4
  } cell_cmd_t;

endpackage

// File: sv/ordered_list_insert_erase_top.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_top
// Fixed-capacity ordered list held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Insert and erase shift the affected entries of the row of cells at once, and
// the read word is picked from the row combinationally, in the same cycle the
// transaction is accepted. The result goes to an output register, so a new
// transaction is accepted every cycle while the output side takes results; the
// input stalls only while a result is held under out_stall. Entry contents are
// not reset; only the count and the output valid flag are, and entries at or above the count are never read.
// ----------------------------------------------------------------------------
module ordered_list_insert_erase_top
  import olie_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_value,
  output logic [4:0]  out_entry_count,
  output logic [1:0]  out_status
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam logic [CMPW-1:0] CAP = CMPW'(CAPACITY);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_read_value_r;
  logic [4:0]    out_entry_count_r;
  status_t       out_status_r;

  logic            accept;
  op_t             op;
  logic [CMPW-1:0] pos_ext, cnt_ext, cnt_new_ext, rsel;
  logic [63:0]     val64, rd64;
  logic [DATA_WIDTH-1:0] new_value, rd_word;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic            rd_en;
  status_t         status;
  cell_cmd_t       cmd;

  assign accept  = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign op      = op_t'(in_operation);
  assign pos_ext = CMPW'(in_position);
  assign cnt_ext = CMPW'(count_r);
  assign val64   = {32'd0, in_value};
  assign new_value = val64[DATA_WIDTH-1:0];

  always_comb begin
    status    = ST_OK;
    cmd       = CC_HOLD;
    count_nxt = count_r;
    rd_en     = 1'b0;
    rsel      = '0;
    case (op)
      OP_PUSH: begin
        if (cnt_ext >= CAP) status = ST_FULL;
        else begin
          cmd       = CC_PUSH;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP: begin
        if (cnt_ext == '0) status = ST_EMPTY;
        else begin
          cmd       = CC_POP;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_INSERT: begin
        if (pos_ext > cnt_ext) status = ST_RANGE;
        else if (cnt_ext >= CAP) status = ST_FULL;
        else begin
          cmd       = CC_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_ERASE: begin
        if (pos_ext >= cnt_ext) status = ST_RANGE;
        else begin
          cmd       = CC_ERASE;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_READ: begin
        if (pos_ext >= cnt_ext) status = ST_RANGE;
        else begin
          rd_en = 1'b1;
          rsel  = pos_ext;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      OP_FRONT: begin
        if (cnt_ext == '0) status = ST_EMPTY;
        else rd_en = 1'b1;
      end
      default: begin
        if (cnt_ext == '0) status = ST_EMPTY;
        else begin
          rd_en = 1'b1;
          rsel  = cnt_ext - CMPW'(1);
        end
      end
    endcase
    if (!accept) begin
      cmd       = CC_HOLD;
      count_nxt = count_r;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_data, upper_data;
      if (gi == 0) begin : g_lo0
        assign lower_data = '0;
      end else begin : g_lo
        assign lower_data = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_hi0
        assign upper_data = '0;
      end else begin : g_hi
        assign upper_data = cell_data[gi+1];
      end
      olie_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .CMPW       (CMPW),
        .INDEX      (gi)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .cmd_pos    (pos_ext),
        .cmd_count  (cnt_ext),
        .new_value  (new_value),
        .lower_data (lower_data),
        .upper_data (upper_data),
        .data       (cell_data[gi])
      );
    end
  endgenerate

  // AND-OR select of the addressed cell
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_en && rsel == CMPW'(i)) rd_word = rd_word | cell_data[i];
    end
  end

  assign rd64        = 64'(rd_word);
  assign cnt_new_ext = CMPW'(count_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r  <= rd64[31:0];
      out_entry_count_r <= cnt_new_ext[4:0];
      out_status_r      <= status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;
  assign out_status      = out_status_r;

endmodule

// File: sv/olie_cell.sv
// ----------------------------------------------------------------------------
// olie_cell
// One list slot. Loads, clears or takes a neighbor's word on each command.
// ----------------------------------------------------------------------------
module olie_cell
  import olie_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int CMPW       = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [CMPW-1:0]       cmd_pos,
  input  logic [CMPW-1:0]       cmd_count,
  input  logic [DATA_WIDTH-1:0] new_value,
  input  logic [DATA_WIDTH-1:0] lower_data,
  input  logic [DATA_WIDTH-1:0] upper_data,
  output logic [DATA_WIDTH-1:0] data
);

  localparam logic [CMPW-1:0] IDX  = CMPW'(INDEX);
  localparam logic [CMPW-1:0] IDX1 = CMPW'(INDEX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd)
      CC_PUSH: begin
        if (IDX == cmd_count) data_nxt = new_value;
      end
      CC_POP: begin
        if (IDX1 == cmd_count) data_nxt = '0;
      end
      CC_INSERT: begin
        if (IDX == cmd_pos) data_nxt = new_value;
        else if (IDX > cmd_pos && IDX <= cmd_count) data_nxt = lower_data;
      end
      CC_ERASE: begin
        if (IDX >= cmd_pos && IDX1 < cmd_count) data_nxt = upper_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: dv/tb_ordered_list_insert_erase_top.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_erase_top
// Self-checking bench for the fixed-capacity ordered list block.
// ----------------------------------------------------------------------------
// A local list model follows every accepted transaction and queues the
// expected read word, count and status. The output monitor pops one entry
// per result and compares it field by field. Directed tests cover the empty
// list, filling to capacity and the cases at the edges of a full list.
// Random tests then walk the count over its whole range under random gaps and
// output stalls, with a long output hold-off, drain pauses and a final
// stretch at full rate.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_erase_top
  import olie_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 16;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    logic [31:0] read_value;
    logic [4:0]  entry_count;
    status_t     status;
  } list_result_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation    = '0;
  logic [4:0]  in_position     = '0;
  logic [31:0] in_value        = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [31:0] out_read_value;
  logic [4:0]  out_entry_count;
  logic [1:0]  out_status;

  // list model state
  logic [31:0]  list_words [CAPACITY];
  int           list_len = 0;
  list_result_t pending_results [$];

  int           err_count   = 0;
  int           result_idx  = 0;
  bit           idle_en     = 1'b1;
  int           hold_req_seq = 0;
  list_result_t want;

  ordered_list_insert_erase_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Applies one operation to the list model and returns the result it gives.
  function automatic list_result_t apply_list_op(op_t op, logic [4:0] pos, logic [31:0] val);
    list_result_t res;
    int           p;
    p = int'(pos);
    res.read_value = '0;
    res.status     = ST_OK;
    case (op)
      OP_PUSH: begin
        if (list_len >= CAPACITY) res.status = ST_FULL;
        else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else begin
          list_len--;
          list_words[list_len] = '0;
        end
      end
      OP_INSERT: begin
        // range check wins over the full check
        if (p > list_len) res.status = ST_RANGE;
        else if (list_len >= CAPACITY) res.status = ST_FULL;
        else begin
          for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = val;
          list_len++;
        end
      end
      OP_ERASE: begin
        if (p >= list_len) res.status = ST_RANGE;
        else begin
          for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (p >= list_len) res.status = ST_RANGE;
        else res.read_value = list_words[p];
      end
      OP_CLEAR: list_len = 0;
      OP_FRONT: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.read_value = list_words[0];
      end
      default: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.read_value = list_words[list_len-1];
      end
    endcase
    res.entry_count = 5'(list_len);
    return res;
  endfunction

  // After an optional random idle gap, offers one transaction, holds it until accepted, then queues its result.
  task automatic send_item(op_t op, logic [4:0] pos, logic [31:0] val);
    int           gap;
    list_result_t exp_res;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    do @(posedge clk); while (in_stall);
    exp_res = apply_list_op(op, pos, val);
    pending_results = {pending_results, exp_res};
  endtask

  task automatic send_random(int target);
    op_t         op;
    logic [4:0]  pos;
    logic [31:0] val;
    int          r;
    int          grow;
    grow = (list_len < target) ? 45 : 15;
    r = $urandom_range(0, 99);
    if (r < grow) op = $urandom_range(0, 1) ? OP_PUSH : OP_INSERT;
    else if (r < 60) op = $urandom_range(0, 1) ? OP_POP : OP_ERASE;
    else if (r < 98) begin
      case ($urandom_range(0, 2))
        0:       op = OP_READ;
        1:       op = OP_FRONT;
        default: op = OP_BACK;
      endcase
    end else op = OP_CLEAR;
    // mostly valid positions, sometimes anything the field holds
    if ($urandom_range(0, 6) == 0) pos = 5'($urandom_range(0, 31));
    else pos = 5'($urandom_range(0, list_len));
    case ($urandom_range(0, 9))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom();
    endcase
    send_item(op, pos, val);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_list();
    send_item(OP_POP,    5'd0, 32'h0);
    send_item(OP_FRONT,  5'd0, 32'h0);
    send_item(OP_BACK,   5'd0, 32'h0);
    send_item(OP_ERASE,  5'd0, 32'h0);
    send_item(OP_INSERT, 5'd1, 32'h1234_5678);
  endtask

  task automatic test_fill_to_capacity();
    send_item(OP_PUSH,   5'd0, 32'h0000_0000);
    send_item(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 5'd2, 32'hAAAA_5555);
    for (int i = 3; i < CAPACITY; i++) begin
      if (i % 4 == 0) send_item(OP_INSERT, 5'(i / 2), $urandom());
      else send_item(OP_PUSH, 5'd31, $urandom());
    end
  endtask

  task automatic test_full_edge_cases();
    send_item(OP_PUSH,   5'd0,  32'hDEAD_BEEF);
    send_item(OP_INSERT, 5'd16, 32'h5555_AAAA);
    send_item(OP_INSERT, 5'd17, 32'h0F0F_0F0F);
    send_item(OP_READ,   5'd15, 32'h0);
    send_item(OP_READ,   5'd31, 32'h0);
    send_item(OP_BACK,   5'd0,  32'h0);
    send_item(OP_ERASE,  5'd15, 32'h0);
    send_item(OP_ERASE,  5'd0,  32'h0);
    send_item(OP_INSERT, 5'd14, 32'hFFFF_FFFF);
    send_item(OP_POP,    5'd0,  32'h0);
    send_item(OP_CLEAR,  5'd0,  32'h0);
    send_item(OP_FRONT,  5'd0,  32'h0);
  endtask

  task automatic test_random_walk();
    int target;
    target = 0;
    for (int i = 0; i < 600; i++) begin
      if (i % 50 == 0) target = $urandom_range(0, CAPACITY);
      send_random(target);
    end
  endtask

  task automatic test_near_full();
    repeat (250) send_random(CAPACITY);
  endtask

  // Output held off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_req_seq++;
    repeat (60) send_random(12);
  endtask

  task automatic test_drain_pauses();
    repeat (4) begin
      repeat (30) send_random($urandom_range(0, CAPACITY));
      wait_drained();
    end
  endtask

  task automatic test_no_idle();
    int target;
    idle_en = 1'b0;
    target  = 0;
    for (int i = 0; i < 300; i++) begin
      if (i % 40 == 0) target = $urandom_range(0, CAPACITY);
      send_random(target);
    end
  endtask

  // Output stall generator: random bursts, plus one long hold-off on request.
  initial begin
    int hold_seen;
    int hold_left;
    int run_left;
    bit stalling;
    hold_seen = 0;
    hold_left = 0;
    run_left  = 0;
    stalling  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_seq != hold_seen) begin
        hold_seen = hold_req_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!idle_en) begin
        out_stall <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else if (!stalling && $urandom_range(0, 2) == 0) begin
        stalling = 1'b1;
        run_left = $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        stalling = 1'b0;
        run_left = $urandom_range(1, 16) - 1;
        out_stall <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("result %0d with nothing pending: rd=%h cnt=%0d st=%0d",
                             result_idx, out_read_value, out_entry_count, out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value || out_entry_count !== want.entry_count ||
            out_status !== want.status)
          note_error($sformatf("result %0d: exp rd=%h cnt=%0d st=%s, got rd=%h cnt=%0d st=%0d",
                               result_idx, want.read_value, want.entry_count,
                               want.status.name(), out_read_value, out_entry_count,
                               out_status));
      end
      result_idx++;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_fill_to_capacity();
    test_full_edge_cases();
    test_random_walk();
    test_near_full();
    test_backpressure();
    test_drain_pauses();
    test_no_idle();
    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
